@@ sv/bdc4_pkg.sv @@
package bdc4_pkg;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Input word kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Size limits and reset sizes
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;

endpackage

@@ sv/bdc4_ram.sv @@
module bdc4_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/binary_dilation_cross4.sv @@
// Results: a pixel's result passes the shift stage and the output register after the word
// one row plus one pixel behind it is accepted (drain words flush the last row).
// Throughput: one word per cycle unless the output stalls, set by the two line-store RAMs,
// each with a read and a write port; reads issue on accept and the last write is forwarded.
// Reset: counters cleared, size 640 x 480 (clamped to the maximums), no result pending.
// The line stores are not cleared; every entry is written in a frame before it is used.
module binary_dilation_cross4 #(
  parameter int MAX_WIDTH  = bdc4_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bdc4_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [bdc4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdc4_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic                           pixel_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           pixel_out,
  output logic                           frame_last
);

  import bdc4_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  typedef struct packed {
    logic res;
    logic first_row;
    logic last_row;
    logic last_col;
    logic down;
  } step_info_t;

  function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                             input int unsigned maxv);
    int unsigned r;
    r = 32'(v);
    if (r == 0) r = 1;
    if (r > maxv) r = maxv;
    return r;
  endfunction

  logic [WW-1:0] image_width;
  logic [HW-1:0] image_height;

  logic [AW-1:0] in_col, in_col_next, out_col, out_col_next;
  logic [HW-1:0] in_row, in_row_next, out_row, out_row_next;
  logic          left_pixel, left_pixel_next;

  logic          acc, step, step_go;
  logic [AW-1:0] s_col;
  step_info_t    s_info;

  logic          b_valid, bstall, b_fire;
  logic [AW-1:0] b_col;
  step_info_t    b_info;

  logic          lw_valid, lw_up, lw_mid;
  logic [AW-1:0] lw_addr;
  logic          right_prev, ctr_prev, mid0;

  logic          u_rdata, m_rdata;
  logic [AW-1:0] m_raddr, b_mid_addr;
  logic          u_raw, m_raw, up, right, ctr, left, down, pix;

  assign acc     = in_valid && !in_stall;
  assign step_go = acc && step;

  // Front end: frame counters and the decision whether this word shifts the line stores.
  always_comb begin
    in_col_next     = in_col;
    in_row_next     = in_row;
    out_col_next    = out_col;
    out_row_next    = out_row;
    left_pixel_next = left_pixel;
    step            = 1'b0;
    if (kind == KIND_DRAIN) begin
      if (in_row >= image_height) begin
        step            = 1'b1;
        left_pixel_next = 1'b0;
      end
    end else begin
      // A pixel after a complete frame starts a new one.
      if (in_row >= image_height) begin
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
      end
      step            = (in_row_next != '0) || (in_col_next != '0);
      left_pixel_next = pixel_in;
    end

    s_col              = out_col_next;
    s_info.res         = (out_row_next != '0);
    s_info.first_row   = (out_row_next == HW'(1));
    s_info.last_row    = (out_row_next >= image_height);
    s_info.last_col    = ((WW'(s_col) + WW'(1)) >= image_width);
    s_info.down        = left_pixel;

    if (step) begin
      if (s_info.last_col) begin
        out_col_next = '0;
        out_row_next = out_row_next + HW'(1);
      end else begin
        out_col_next = s_col + AW'(1);
      end
      if (s_info.res && s_info.last_row && s_info.last_col) begin
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
      end
    end

    if (kind == KIND_PIXEL) begin
      if ((WW'(in_col_next) + WW'(1)) >= image_width) begin
        in_col_next = '0;
        in_row_next = in_row_next + HW'(1);
      end else begin
        in_col_next = in_col_next + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WW'(RST_W);
      image_height <= HW'(RST_H);
      in_col       <= '0;
      in_row       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      left_pixel   <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= WW'(clamp_size(cfg_data, MAX_WIDTH));
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= HW'(clamp_size(cfg_data, MAX_HEIGHT));
      end
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (acc) begin
      in_col     <= in_col_next;
      in_row     <= in_row_next;
      out_col    <= out_col_next;
      out_row    <= out_row_next;
      left_pixel <= left_pixel_next;
    end
  end

  // Line stores: upper is read at the shift column, middle one column to the right.
  assign m_raddr = AW'(WW'(s_col) + WW'(1));

  bdc4_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (b_fire),
    .waddr (b_col),
    .wdata (ctr),
    .re    (step_go),
    .raddr (s_col),
    .rdata (u_rdata)
  );

  bdc4_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (b_fire),
    .waddr (b_col),
    .wdata (b_info.down),
    .re    (step_go),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // Shift stage: the previous write is the newest value of its entry, so it wins on a match.
  assign b_mid_addr = AW'(WW'(b_col) + WW'(1));
  assign u_raw = (lw_valid && (lw_addr == b_col)) ? lw_up : u_rdata;
  assign m_raw = (lw_valid && (lw_addr == b_mid_addr)) ? lw_mid : m_rdata;

  // Column zero takes its center from a copy of middle[0]; elsewhere the center is the
  // right neighbor read by the step before, and the left is that step's center.
  assign up    = b_info.first_row ? 1'b0 : u_raw;
  assign right = b_info.last_col ? 1'b0 : m_raw;
  assign ctr   = (b_col == '0) ? mid0 : right_prev;
  assign left  = (b_col == '0) ? 1'b0 : ctr_prev;
  assign down  = b_info.last_row ? 1'b0 : b_info.down;
  assign pix   = ctr | up | down | left | right;

  assign bstall   = b_valid && b_info.res && out_valid && out_stall;
  assign b_fire   = b_valid && !bstall;
  assign in_stall = bstall;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid  <= 1'b0;
      lw_valid <= 1'b0;
      mid0     <= 1'b0;
    end else begin
      if (!bstall) begin
        b_valid <= step_go;
      end
      if (b_fire) begin
        lw_valid <= 1'b1;
        if (b_col == '0) begin
          mid0 <= b_info.down;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!bstall) begin
      b_col  <= s_col;
      b_info <= s_info;
    end
    if (b_fire) begin
      lw_addr    <= b_col;
      lw_up      <= ctr;
      lw_mid     <= b_info.down;
      right_prev <= m_raw;
      ctr_prev   <= ctr;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire && b_info.res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_info.res) begin
      pixel_out  <= pix;
      frame_last <= b_info.last_row && b_info.last_col;
    end
  end

endmodule

@@ sv/bdc4_checker.sv @@
module bdc4_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic pixel_out,
  input logic frame_last
);

  // A waiting result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_last))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // The input side only stalls while a result word is waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output register");

  // A new result word traces back to an accepted input word, through the shift stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result word without an input word two cycles before");

endmodule

bind binary_dilation_cross4 bdc4_checker u_bdc4_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_out  (pixel_out),
  .frame_last (frame_last)
);

@@ sim/dilation_checker.sv @@
module dilation_checker
  import bdc4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 kind,
  input  logic                 pixel_in,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 pixel_out,
  input  logic                 frame_last,
  output int                   failures,
  output int                   pending
);

  typedef struct packed {
    logic pixel;
    logic last;
  } dilated_word_t;

  dilated_word_t dilated_q[$];

  // row_above holds the older of the two buffered rows, row_current the newer one.
  bit          row_above   [MAX_WIDTH_DEF];
  bit          row_current [MAX_WIDTH_DEF];
  int unsigned img_w;
  int unsigned img_h;
  int unsigned src_col;
  int unsigned src_line;
  int unsigned emit_col;
  int unsigned emit_line;
  bit          prev_pixel;

  function automatic int unsigned limit_size(logic [CFG_W-1:0] value, int unsigned top);
    int unsigned v;
    v = value;
    if (v == 0) v = 1;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic void clear_counters();
    src_col   = 0;
    src_line  = 0;
    emit_col  = 0;
    emit_line = 0;
  endfunction

  // Moves one column through the line stores; from the second row on it yields a word.
  function automatic void shift_column();
    int unsigned   c;
    bit            up;
    bit            center;
    bit            right;
    bit            left;
    bit            down;
    bit            bottom_row;
    bit            frame_done;
    dilated_word_t w;
    c          = emit_col;
    up         = row_above[c];
    center     = row_current[c];
    right      = (c + 1 < img_w) ? row_current[c + 1] : 1'b0;
    left       = (c > 0) ? row_above[c - 1] : 1'b0;
    down       = prev_pixel;
    frame_done = 1'b0;
    row_above[c]   = center;
    row_current[c] = prev_pixel;
    if (emit_line > 0) begin
      bottom_row = (emit_line >= img_h);
      if (emit_line == 1) up = 1'b0;
      if (bottom_row) down = 1'b0;
      w.pixel    = center | up | down | left | right;
      w.last     = bottom_row && (c + 1 >= img_w);
      frame_done = w.last;
      dilated_q.push_back(w);
    end
    emit_col = c + 1;
    if (emit_col >= img_w) begin
      emit_col = 0;
      emit_line++;
    end
    if (frame_done) clear_counters();
  endfunction

  function automatic void dilate_word(logic k, logic p);
    if (k == KIND_DRAIN) begin
      // A drain only counts once the whole frame is in.
      if (src_line < img_h) return;
      shift_column();
      prev_pixel = 1'b0;
      return;
    end
    if (src_line >= img_h) clear_counters();
    if (src_line != 0 || src_col != 0) shift_column();
    prev_pixel = p;
    src_col++;
    if (src_col >= img_w) begin
      src_col = 0;
      src_line++;
    end
  endfunction

  always @(posedge clk) begin
    dilated_word_t want;
    if (rst) begin
      img_w      = limit_size(CFG_W'(RESET_WIDTH), MAX_WIDTH_DEF);
      img_h      = limit_size(CFG_W'(RESET_HEIGHT), MAX_HEIGHT_DEF);
      prev_pixel = 1'b0;
      foreach (row_above[i]) begin
        row_above[i]   = 1'b0;
        row_current[i] = 1'b0;
      end
      clear_counters();
      dilated_q.delete();
      failures = 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (dilated_q.size() == 0) begin
          $error("output word with nothing expected: pixel_out %0b frame_last %0b",
                 pixel_out, frame_last);
          failures++;
        end else begin
          want = dilated_q.pop_front();
          if (pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0b, got %0b", want.pixel, pixel_out);
            failures++;
          end
          if (frame_last !== want.last) begin
            $error("frame_last: expected %0b, got %0b", want.last, frame_last);
            failures++;
          end
        end
      end
      if (cfg_write === 1'b1) begin
        if (cfg_index == REG_IMAGE_WIDTH) img_w = limit_size(cfg_data, MAX_WIDTH_DEF);
        else img_h = limit_size(cfg_data, MAX_HEIGHT_DEF);
        clear_counters();
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) dilate_word(kind, pixel_in);
    end
    pending = dilated_q.size();
  end

endmodule

@@ sim/testbench.sv @@
module testbench;
  import bdc4_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 kind;
  logic                 pixel_in;
  logic                 out_valid;
  logic                 out_stall;
  logic                 pixel_out;
  logic                 frame_last;
  int                   failures;
  int                   pending;

  bit          tx_busy;
  bit          rx_busy;
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned counted;

  binary_dilation_cross4 dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

  dilation_checker dilation_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_out  (pixel_out),
    .frame_last (frame_last),
    .failures   (failures),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("testbench: errors");
    $finish;
  end

  // Output side: after each accepted word, stall is raised at random while rx_busy is set.
  initial begin
    int unsigned hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_stall) begin
        hold--;
        if (hold == 0) out_stall <= 1'b0;
      end else if (!rst && out_valid === 1'b1) begin
        hold = rx_busy ? $urandom_range(0, 6) : 0;
        if (hold != 0) out_stall <= 1'b1;
      end
    end
  end

  function automatic int unsigned effective_size(logic [CFG_W-1:0] value, int unsigned top);
    if (value == 0) return 1;
    if (value > top) return top;
    return value;
  endfunction

  task automatic send_word(logic k, logic p);
    int unsigned gap;
    gap = tx_busy ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    pixel_in <= p;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Stops sending and waits until every expected word is out and the pipeline is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) frame_w = effective_size(value, MAX_WIDTH_DEF);
    else frame_h = effective_size(value, MAX_HEIGHT_DEF);
  endtask

  task automatic send_frame(int unsigned pixels, int unsigned drains, int unsigned density);
    for (int i = 0; i < pixels; i++) begin
      // A stray drain in the middle of the frame must be ignored.
      if (i > 0 && $urandom_range(0, 19) == 0) send_word(KIND_DRAIN, 1'($urandom_range(0, 1)));
      send_word(KIND_PIXEL, $urandom_range(0, 99) < density);
    end
    repeat (drains) send_word(KIND_DRAIN, 1'($urandom_range(0, 1)));
    counted += pixels + drains;
  endtask

  initial begin
    logic [5:0]  pattern;
    int unsigned style;
    int unsigned frame_no;
    int unsigned nw;
    int unsigned nh;
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    kind      <= KIND_PIXEL;
    pixel_in  <= 1'b0;
    tx_busy   = 1'b1;
    rx_busy   = 1'b1;
    frame_w   = RESET_WIDTH;
    frame_h   = RESET_HEIGHT;
    counted   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // A drain with no frame behind it, then a reset-size frame cut short by a write.
    send_word(KIND_DRAIN, 1'b1);
    send_word(KIND_PIXEL, 1'b1);
    send_word(KIND_PIXEL, 1'b0);

    // Zero sizes clamp to a single pixel; the third drain finds nothing pending.
    write_size(REG_IMAGE_WIDTH, '0);
    write_size(REG_IMAGE_HEIGHT, '0);
    send_word(KIND_PIXEL, 1'b1);
    repeat (3) send_word(KIND_DRAIN, 1'b0);

    write_size(REG_IMAGE_WIDTH, 11'd3);
    write_size(REG_IMAGE_HEIGHT, 11'd2);
    pattern = 6'b100001;
    for (int i = 0; i < 6; i++) begin
      if (i == 2) send_word(KIND_DRAIN, 1'b1);
      send_word(KIND_PIXEL, pattern[i]);
    end
    repeat (4) send_word(KIND_DRAIN, 1'b1);

    // One-row image: the first drain gives nothing, and a pixel then starts a new frame.
    write_size(REG_IMAGE_WIDTH, 11'd2);
    write_size(REG_IMAGE_HEIGHT, 11'd1);
    send_word(KIND_PIXEL, 1'b0);
    send_word(KIND_PIXEL, 1'b1);
    send_word(KIND_DRAIN, 1'b0);
    send_word(KIND_PIXEL, 1'b1);
    send_word(KIND_PIXEL, 1'b0);
    repeat (3) send_word(KIND_DRAIN, 1'b0);

    counted  = 0;
    frame_no = 0;
    while (counted < 1350) begin
      tx_busy = ($urandom_range(0, 3) != 0);
      rx_busy = ($urandom_range(0, 3) != 0);
      style   = $urandom_range(0, 9);
      if (frame_no == 3) begin
        // A height above the maximum clamps to it; one column keeps the frame short.
        write_size(REG_IMAGE_WIDTH, 11'd1);
        write_size(REG_IMAGE_HEIGHT, 11'h7ff);
        style = 0;
      end else if (frame_no == 0 || frame_no == 4 || frame_no == 10 || frame_no == 15
                   || $urandom_range(0, 3) == 0) begin
        nw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
        nh = $urandom_range(1, 8);
        if ($urandom_range(0, 1)) begin
          write_size(REG_IMAGE_WIDTH, CFG_W'(nw));
          write_size(REG_IMAGE_HEIGHT, CFG_W'(nh));
        end else begin
          write_size(REG_IMAGE_HEIGHT, CFG_W'(nh));
          write_size(REG_IMAGE_WIDTH, CFG_W'(nw));
        end
      end
      if (style <= 6) begin
        send_frame(frame_w * frame_h,
                   frame_w + 1 + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0),
                   $urandom_range(0, 100));
      end else if (style == 7) begin
        // Too few drains: the next pixel abandons what is left of this frame.
        send_frame(frame_w * frame_h, $urandom_range(0, frame_w), $urandom_range(0, 100));
      end else if (style == 8) begin
        send_frame($urandom_range(1, frame_w * frame_h), 0, $urandom_range(0, 100));
        if ($urandom_range(0, 1)) write_size(REG_IMAGE_WIDTH, CFG_W'(frame_w));
        else write_size(REG_IMAGE_HEIGHT, CFG_W'(frame_h));
      end else begin
        repeat ($urandom_range(1, 10))
          send_word($urandom_range(0, 1) ? KIND_DRAIN : KIND_PIXEL,
                    1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 7) == 0) settle();
      frame_no++;
    end

    settle();
    if (failures == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
